// File: rtl/core/clsc_pkg.sv
// Package for the contig length sort and cumulative sum block.
// Holds sizes, request and result payload structs, the sequencer state type and the compare control struct.
// Depends on nothing.
package clsc_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int LEN_W = 32;
    localparam int LINE_W = 16;
    localparam int CUM_W = 38;

    typedef struct packed {
        logic              is_header;
        logic [LINE_W-1:0] line_length;
        logic              end_of_file;
    } in_t;

    typedef struct packed {
        logic [LEN_W-1:0] record_length;
        logic [CUM_W-1:0] cumulative_length;
        logic             last;
        logic             overflowed;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK
    } state_t;

    // Control of the shared compare unit for one cycle.
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic             used;
        logic [IDX_W-1:0] idx;
    } cmp_ctl_t;

endpackage

// File: rtl/core/clsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module clsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/clsc_max_unit.sv
// Shared compare unit: tracks the largest unused length seen during one scan of the store.
// Depends on clsc_pkg.
module clsc_max_unit (
    input  logic                          aclk,
    input  clsc_pkg::cmp_ctl_t            ctl,
    input  logic [clsc_pkg::LEN_W-1:0]    cand_len,
    output logic [clsc_pkg::LEN_W-1:0]    best_len,
    output logic [clsc_pkg::IDX_W-1:0]    best_idx
);

    logic [clsc_pkg::LEN_W-1:0] best_len_reg, best_len_next;
    logic [clsc_pkg::IDX_W-1:0] best_idx_reg, best_idx_next;

    // Kept lengths are never zero, so a cleared best of zero loses to any entry.
    always_comb begin
        best_len_next = best_len_reg;
        best_idx_next = best_idx_reg;
        if (ctl.clear) begin
            best_len_next = '0;
            best_idx_next = '0;
        end else if (ctl.valid && !ctl.used && (cand_len > best_len_reg)) begin
            best_len_next = cand_len;
            best_idx_next = ctl.idx;
        end
    end

    always_ff @(posedge aclk) begin
        best_len_reg <= best_len_next;
        best_idx_reg <= best_idx_next;
    end

    assign best_len = best_len_reg;
    assign best_idx = best_idx_reg;

endmodule

// File: rtl/core/contig_length_sort_cumsum.sv
// Top level of the contig length sort and cumulative sum block.
// Depends on clsc_pkg, clsc_ram and clsc_max_unit.
//
// The block takes one request per line of a sequence record file and accepts one line request
// per clock cycle while idle. Sequence line lengths add into a running record length that
// saturates at 2^32-1. A header or an end-of-file request closes the record, which is kept in
// a 64-entry RAM when it is longer than the programmed minimum; a record that finds the store
// full is dropped and sets the overflowed flag of the run. After end of file the block stops
// taking requests and emits the kept lengths largest first, each with its running sum. Every
// result is found by a full scan of the store through the single RAM read port and one
// comparator, after which the winner moves into the output register; a stall on the result
// channel holds the block until that register is free. A run with nothing kept gives no
// results. The final result may still wait in the output register while the next run's line
// requests are taken. The minimum length is written through cfg_wr_en and cfg_wr_data and
// survives end of file; the user must write it only while the block is idle, since the block
// itself does not enforce this.
module contig_length_sort_cumsum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [clsc_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  clsc_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output clsc_pkg::out_t             m_data
);

    localparam int LEN_W = clsc_pkg::LEN_W;
    localparam int CNT_W = clsc_pkg::CNT_W;
    localparam int IDX_W = clsc_pkg::IDX_W;
    localparam int CUM_W = clsc_pkg::CUM_W;
    localparam int MAXR  = clsc_pkg::MAX_RECORDS;

    clsc_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0] min_len_reg;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [MAXR-1:0]  used_reg, used_next;
    logic [CUM_W-1:0] cum_reg, cum_next;
    logic             m_valid_reg, m_valid_next;
    clsc_pkg::out_t   m_data_reg, m_data_next;

    logic             s_fire;
    logic [LEN_W:0]   sum_wide;
    logic             qualify;
    logic             room;
    logic             wr_en;
    logic [LEN_W-1:0] rd_data;
    logic [LEN_W-1:0] best_len;
    logic [IDX_W-1:0] best_idx;
    logic [CUM_W-1:0] cum_sum;
    logic             out_free;
    logic             is_last;
    clsc_pkg::cmp_ctl_t cmp_ctl;

    assign s_ready  = (state_reg == clsc_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign sum_wide = {1'b0, cur_len_reg} + {{(LEN_W + 1 - clsc_pkg::LINE_W){1'b0}},
                                             s_data.line_length};
    assign qualify  = (cur_len_reg > min_len_reg);
    assign room     = (count_reg < CNT_W'(MAXR));
    // A record is written into the store when it closes and qualifies with room left.
    assign wr_en    = s_fire && (s_data.is_header || s_data.end_of_file) && qualify && room;
    assign cum_sum  = cum_reg + {{(CUM_W - LEN_W){1'b0}}, best_len};
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (CNT_W'(emit_reg + 1'b1) == count_reg);

    clsc_ram #(
        .WIDTH(LEN_W),
        .DEPTH(MAXR)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cur_len_reg),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    clsc_max_unit u_max (
        .aclk     (aclk),
        .ctl      (cmp_ctl),
        .cand_len (rd_data),
        .best_len (best_len),
        .best_idx (best_idx)
    );

    always_comb begin
        state_next   = state_reg;
        cur_len_next = cur_len_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        scan_next    = scan_reg;
        emit_next    = emit_reg;
        pend_next    = 1'b0;
        cmp_idx_next = scan_reg[IDX_W-1:0];
        used_next    = used_reg;
        cum_next     = cum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        // The compare unit sees the entry whose read was issued in the previous cycle.
        cmp_ctl.clear = 1'b0;
        cmp_ctl.valid = pend_reg;
        cmp_ctl.used  = used_reg[cmp_idx_reg];
        cmp_ctl.idx   = cmp_idx_reg;

        unique case (state_reg)
            clsc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.is_header || s_data.end_of_file) begin
                        cur_len_next = '0;
                        if (qualify) begin
                            if (room) begin
                                count_next = CNT_W'(count_reg + 1'b1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                    end else if (sum_wide[LEN_W]) begin
                        cur_len_next = '1;
                    end else begin
                        cur_len_next = sum_wide[LEN_W-1:0];
                    end

                    if (s_data.end_of_file) begin
                        if (count_next == '0) begin
                            ovf_next = 1'b0;
                        end else begin
                            state_next    = clsc_pkg::ST_SCAN;
                            scan_next     = '0;
                            emit_next     = '0;
                            cum_next      = '0;
                            cmp_ctl.clear = 1'b1;
                        end
                    end
                end
            end
            clsc_pkg::ST_SCAN: begin
                if (scan_reg == count_reg) begin
                    state_next = clsc_pkg::ST_PICK;
                end else begin
                    pend_next = 1'b1;
                    scan_next = CNT_W'(scan_reg + 1'b1);
                end
            end
            clsc_pkg::ST_PICK: begin
                if (out_free) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.record_length     = best_len;
                    m_data_next.cumulative_length = cum_sum;
                    m_data_next.last              = is_last;
                    m_data_next.overflowed        = ovf_reg;
                    if (is_last) begin
                        state_next = clsc_pkg::ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        used_next  = '0;
                        cum_next   = '0;
                    end else begin
                        state_next          = clsc_pkg::ST_SCAN;
                        used_next[best_idx] = 1'b1;
                        cum_next            = cum_sum;
                        emit_next           = CNT_W'(emit_reg + 1'b1);
                        scan_next           = '0;
                        cmp_ctl.clear       = 1'b1;
                    end
                end
            end
            default: begin
                state_next = clsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clsc_pkg::ST_IDLE;
            min_len_reg <= '0;
            cur_len_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            scan_reg    <= '0;
            emit_reg    <= '0;
            pend_reg    <= 1'b0;
            used_reg    <= '0;
            cum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
            cur_len_reg <= cur_len_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            scan_reg    <= scan_next;
            emit_reg    <= emit_next;
            pend_reg    <= pend_next;
            used_reg    <= used_next;
            cum_reg     <= cum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
